// ===== sv/bdpt_pkg.sv =====
// Shared types and constants for the button debounce / press timer unit.
// No dependencies; imported by bdpt_ms_conv, button_debounce_press_timer_unit and the bench.
package bdpt_pkg;

    // Debounce machine state, one-hot
    typedef enum logic [3:0] {
        PH_UP      = 4'b0001,
        PH_FALLING = 4'b0010,
        PH_DOWN    = 4'b0100,
        PH_RISING  = 4'b1000
    } t_phase;

    // Phase codes as reported on the result stream
    localparam logic [1:0] PHASE_CODE_UP      = 2'd0;
    localparam logic [1:0] PHASE_CODE_DOWN    = 2'd1;
    localparam logic [1:0] PHASE_CODE_RISING  = 2'd2;
    localparam logic [1:0] PHASE_CODE_FALLING = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL_US = 1'b1;

    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RST        = 16'd20;
    localparam logic [TIME_W-1:0]     REPORT_INTERVAL_US_RST = 32'd5000000;

    // us -> ms: floor(t / 1000) == (t * ceil(2^38 / 1000)) >> 38 for any 32-bit t
    localparam int MS_MAGIC_W = 29;
    localparam logic [MS_MAGIC_W-1:0] MS_MAGIC = 29'd274877907;
    localparam int MS_SHIFT  = 38;
    localparam int MS_PROD_W = TIME_W + MS_MAGIC_W;
    localparam int MS_W      = MS_PROD_W - MS_SHIFT;   // 23 bits covers 2^32 / 1000

    // Stream payload widths (bytes-rounded)
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_UP:      code = PHASE_CODE_UP;
            PH_DOWN:    code = PHASE_CODE_DOWN;
            PH_RISING:  code = PHASE_CODE_RISING;
            PH_FALLING: code = PHASE_CODE_FALLING;
            default:    code = PHASE_CODE_UP;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/button_debounce_press_timer_unit.sv =====
// Top level: button debouncer with press-duration LED timer and report strobe.
// Depends on bdpt_pkg and bdpt_ms_conv.
//
//  channel   | direction | signals                               | one request carries
//  ----------+-----------+---------------------------------------+------------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready/tdata | one tick: time_us, button_level
//  m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready/tdata | state after that tick
//  cfg       | in        | i_cfg_valid/o_cfg_ready/index/data    | one register write
//
// One tick per clock sustained unless stalled. A tick passes the input register, the
// millisecond conversion register (the one multiplier), then the state update into
// the result register. Each stage advances independently, so bubbles collapse and a
// new tick is taken while a result waits. The result fields are read straight from
// the state registers, which only change when a tick moves into the result slot.
// Reset (i_rst_n low, synchronous) empties the pipe and restores the register defaults.
// Configuration is always ready; write it only while the pipe is empty.
module button_debounce_press_timer_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: [31:0] time_us, [32] button_level, [39:33] zero
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [bdpt_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // tdata: [0] led, [2:1] button_phase, [34:3] press_total,
    //        [66:35] pending_duration_ms, [67] report_strobe, [71:68] zero
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [bdpt_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // index 0 debounce_ms (data[15:0]), index 1 report_interval_us
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bdpt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bdpt_pkg::TIME_W-1:0]          i_cfg_data
);
    import bdpt_pkg::*;

    // ---------------- configuration ----------------
    logic [DEBOUNCE_W-1:0] r_debounce_ms;
    logic [TIME_W-1:0]     r_report_interval;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms     <= DEBOUNCE_MS_RST;
            r_report_interval <= REPORT_INTERVAL_US_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE_MS:        r_debounce_ms     <= i_cfg_data[DEBOUNCE_W-1:0];
                CFG_REPORT_INTERVAL_US: r_report_interval <= i_cfg_data;
                default:                ;
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic w_out_ready, w_s2_ready, w_s1_ready;
    logic w_in_fire, w_s1_fire, w_s2_fire;

    assign w_out_ready = !r_out_valid || i_m_axis_tready;
    assign w_s2_ready  = !r_s2_valid || w_out_ready;
    assign w_s1_ready  = !r_s1_valid || w_s2_ready;

    assign w_in_fire = i_s_axis_tvalid && w_s1_ready;
    assign w_s1_fire = r_s1_valid && w_s2_ready;
    assign w_s2_fire = r_s2_valid && w_out_ready;

    assign o_s_axis_tready = w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready)  r_s1_valid  <= i_s_axis_tvalid;
            if (w_s2_ready)  r_s2_valid  <= r_s1_valid;
            if (w_out_ready) r_out_valid <= r_s2_valid;
        end
    end

    // Stage 1: input register
    logic [TIME_W-1:0] r_s1_us;
    logic              r_s1_level;

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_us    <= i_s_axis_tdata[TIME_W-1:0];
            r_s1_level <= i_s_axis_tdata[TIME_W];
        end
    end

    // Stage 2: millisecond time alongside the raw tick
    logic [TIME_W-1:0] r_s2_us;
    logic              r_s2_level;
    logic [MS_W-1:0]   w_s2_ms;

    bdpt_ms_conv u_ms_conv (
        .i_clk     (i_clk),
        .i_en      (w_s1_fire),
        .i_time_us (r_s1_us),
        .o_time_ms (w_s2_ms)
    );

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_s2_us    <= r_s1_us;
            r_s2_level <= r_s1_level;
        end
    end

    // ---------------- state update ----------------
    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_press_start, n_press_start;
    logic [TIME_W-1:0] r_last_change, n_last_change;
    logic [TIME_W-1:0] r_duration, n_duration;
    logic [TIME_W-1:0] r_press_total, n_press_total;
    logic              r_led, n_led;
    logic [TIME_W-1:0] r_deadline, n_deadline;
    logic [TIME_W-1:0] r_last_report, n_last_report;
    logic              r_strobe, n_strobe;

    logic [TIME_W-1:0] w_now_ms;
    logic              w_settled;
    logic [TIME_W-1:0] w_dur_mid;
    logic              w_led_start;
    logic [TIME_W-1:0] w_dur_x1000;
    logic [TIME_W:0]   w_deadline_sum;
    logic              w_led_off;

    assign w_now_ms  = TIME_W'(w_s2_ms);
    assign w_settled = (w_now_ms - r_last_change) >= TIME_W'(r_debounce_ms);

    // Debounce machine; a falling/rising phase is settled by the very next tick
    // without a debounce check.
    always_comb begin
        n_phase       = r_phase;
        n_press_start = r_press_start;
        n_last_change = r_last_change;
        w_dur_mid     = r_duration;
        n_press_total = r_press_total;
        unique case (r_phase)
            PH_UP: begin
                if (!r_s2_level && w_settled) begin
                    n_phase       = PH_FALLING;
                    n_last_change = w_now_ms;
                end
            end
            PH_FALLING: begin
                if (!r_s2_level) begin
                    n_phase       = PH_DOWN;
                    n_press_start = w_now_ms;
                end else begin
                    n_phase = PH_UP;
                end
            end
            PH_DOWN: begin
                if (r_s2_level && w_settled) begin
                    n_phase       = PH_RISING;
                    n_last_change = w_now_ms;
                end
            end
            PH_RISING: begin
                if (r_s2_level) begin
                    n_phase       = PH_UP;
                    w_dur_mid     = w_now_ms - r_press_start;
                    n_press_total = r_press_total + TIME_W'(1);
                end else begin
                    n_phase = PH_DOWN;
                end
            end
            default: n_phase = PH_UP;
        endcase
    end

    // LED: a pending duration lights it once the machine is up and the LED is dark.
    // duration * 1000 as shifts: 1024 - 16 - 8.
    assign w_dur_x1000 = (w_dur_mid << 10) - (w_dur_mid << 4) - (w_dur_mid << 3);
    assign w_deadline_sum = {1'b0, r_s2_us} + {1'b0, w_dur_x1000};
    assign w_led_start = (n_phase == PH_UP) && (w_dur_mid != '0) && !r_led;

    // A fresh deadline is already reached when the add wraps or adds nothing.
    assign w_led_off = w_led_start
        ? (w_deadline_sum[TIME_W] || (w_dur_x1000 == '0))
        : (r_s2_us >= r_deadline);

    always_comb begin
        n_deadline = w_led_start ? w_deadline_sum[TIME_W-1:0] : r_deadline;
        n_duration = w_led_start ? '0 : w_dur_mid;
        n_led      = (r_led || w_led_start) && !w_led_off;
    end

    // Report strobe
    always_comb begin
        n_strobe      = (r_s2_us - r_last_report) >= r_report_interval;
        n_last_report = n_strobe ? r_s2_us : r_last_report;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_UP;
            r_press_start <= '0;
            r_last_change <= '0;
            r_duration    <= '0;
            r_press_total <= '0;
            r_led         <= 1'b0;
            r_deadline    <= '0;
            r_last_report <= '0;
            r_strobe      <= 1'b0;
        end else if (w_s2_fire) begin
            r_phase       <= n_phase;
            r_press_start <= n_press_start;
            r_last_change <= n_last_change;
            r_duration    <= n_duration;
            r_press_total <= n_press_total;
            r_led         <= n_led;
            r_deadline    <= n_deadline;
            r_last_report <= n_last_report;
            r_strobe      <= n_strobe;
        end
    end

    // ---------------- result stream ----------------
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_strobe, r_duration, r_press_total,
                              phase_code(r_phase), r_led};

    // ---------------- assertions ----------------
    a_phase_moves_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_phase != $past(r_phase))) |-> $past(w_s2_fire))
        else $error("debounce phase changed without a tick update");

    a_count_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_press_total != $past(r_press_total)))
            |-> $past(w_s2_fire && (r_phase == PH_RISING) && r_s2_level))
        else $error("press count moved outside a confirmed release");

    a_led_on_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_led)) |-> ($past(w_s2_fire) && (r_duration == '0)))
        else $error("LED lit but pending duration not consumed");

    a_result_from_stage2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(r_s2_valid))
        else $error("result appeared without a tick in the update stage");

endmodule

// ===== sv/bdpt_ms_conv.sv =====
// Registered microsecond-to-millisecond converter (reciprocal multiply).
// Depends on bdpt_pkg for the reciprocal constant and widths.
module bdpt_ms_conv (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [bdpt_pkg::TIME_W-1:0]   i_time_us,
    output logic [bdpt_pkg::MS_W-1:0]     o_time_ms
);
    import bdpt_pkg::*;

    logic [MS_PROD_W-1:0] w_prod;
    logic [MS_W-1:0]      r_time_ms;

    assign w_prod = MS_PROD_W'(i_time_us) * MS_PROD_W'(MS_MAGIC);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_time_ms <= w_prod[MS_PROD_W-1:MS_SHIFT];
        end
    end

    assign o_time_ms = r_time_ms;

endmodule

// ===== tb/button_debounce_press_timer_unit_tb.sv =====
// Self-checking bench for button_debounce_press_timer_unit: directed ticks, then press-shaped
// random traffic under several register settings. Depends on bdpt_pkg and the unit itself.
module button_debounce_press_timer_unit_tb;
    import bdpt_pkg::*;

    // Expected contents of one result request, MSB first so it lines up with tdata[67:0]
    typedef struct packed {
        logic        strobe;
        logic [31:0] pending;
        logic [31:0] total;
        logic [1:0]  phase;
        logic        led;
    } t_tick_result;

    // One tick to send; fixed rows carry their expected result typed in
    typedef struct packed {
        logic [31:0]  t_us;
        logic         lvl;
        logic         fixed;
        t_tick_result res;
    } t_tick_row;

    localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles before giving up
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int SETTLE_CYCLES  = 8;      // pipe is three deep

    localparam t_tick_result NO_CHECK     = '0;
    localparam t_tick_result AFTER_RESET  = '{strobe: 1'b0, pending: 32'd0, total: 32'd0,
                                              phase: PHASE_CODE_UP, led: 1'b0};
    localparam t_tick_result FIRST_REPORT = '{strobe: 1'b1, pending: 32'd0, total: 32'd0,
                                              phase: PHASE_CODE_UP, led: 1'b0};

    // Directed walk, run with reset register values (debounce 20 ms, report every 5 s)
    localparam int N_DIRECTED = 27;
    localparam t_tick_row DIRECTED_TICKS [N_DIRECTED] = '{
        '{32'd0,          1'b1, 1'b1, AFTER_RESET},   // first tick after reset, time zero
        '{32'd5_000_000,  1'b1, 1'b1, FIRST_REPORT},  // report interval exactly reached
        '{32'd5_010_000,  1'b0, 1'b0, NO_CHECK},      // up -> falling
        '{32'd5_011_000,  1'b1, 1'b0, NO_CHECK},      // chatter: falling back to up
        '{32'd5_012_000,  1'b0, 1'b0, NO_CHECK},      // too soon, debounce rejects
        '{32'd5_030_000,  1'b0, 1'b0, NO_CHECK},      // exactly debounce later: falling
        '{32'd5_031_000,  1'b0, 1'b0, NO_CHECK},      // confirmed down, press starts
        '{32'd5_040_000,  1'b1, 1'b0, NO_CHECK},      // release too soon
        '{32'd5_050_000,  1'b1, 1'b0, NO_CHECK},      // down -> rising
        '{32'd5_051_000,  1'b0, 1'b0, NO_CHECK},      // chatter: rising back to down
        '{32'd5_080_000,  1'b1, 1'b0, NO_CHECK},      // rising again
        '{32'd5_081_000,  1'b1, 1'b0, NO_CHECK},      // release confirmed, LED lit
        '{32'd5_101_000,  1'b0, 1'b0, NO_CHECK},      // second press while LED is on
        '{32'd5_102_000,  1'b0, 1'b0, NO_CHECK},
        '{32'd5_122_000,  1'b1, 1'b0, NO_CHECK},
        '{32'd5_123_000,  1'b1, 1'b0, NO_CHECK},      // duration waits, LED still on
        '{32'd5_131_000,  1'b1, 1'b0, NO_CHECK},      // deadline hit, LED off
        '{32'd5_132_000,  1'b1, 1'b0, NO_CHECK},      // waiting duration lights LED
        '{32'd5_160_000,  1'b0, 1'b0, NO_CHECK},      // zero-length press begins
        '{32'd5_160_500,  1'b0, 1'b0, NO_CHECK},
        '{32'd5_180_000,  1'b1, 1'b0, NO_CHECK},
        '{32'd5_160_900,  1'b1, 1'b0, NO_CHECK},      // time steps back: zero length, no LED
        '{32'hFFFF_0000,  1'b0, 1'b0, NO_CHECK},      // press just below the wrap
        '{32'hFFFF_0400,  1'b0, 1'b0, NO_CHECK},
        '{32'hFFFF_8000,  1'b1, 1'b0, NO_CHECK},
        '{32'hFFFF_8400,  1'b1, 1'b0, NO_CHECK},      // deadline wraps, LED off at once
        '{32'hFFFF_FFFF,  1'b1, 1'b0, NO_CHECK}       // largest timestamp
    };

    // DUT signals; the inputs are known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_valid   = 1'b0;
    logic [IN_DATA_W-1:0]  s_data    = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [TIME_W-1:0]     cfg_data  = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  cfg_ready;

    // Predictor copy of the registers and the block state
    logic [15:0] db_ms;
    logic [31:0] rpt_us;
    logic [1:0]  ph;
    logic [31:0] start_ms;
    logic [31:0] last_chg_ms;
    logic [31:0] held_ms;
    logic [31:0] presses;
    logic        led_on;
    logic [31:0] led_off_at;
    logic [31:0] last_rpt_us;

    t_tick_row    tick_q[$];        // ticks not yet offered
    t_tick_result tick_result_q[$]; // expected results, oldest first
    t_tick_row    cur = '0;         // tick currently offered
    logic         offering = 1'b0;
    int           gap_left = 0;
    logic         idle_on = 1'b1;
    int           hold_asks = 0;
    int           hold_seen = 0;
    int           hold_left = 0;
    int           stall_left = 0;
    int           quiet = 0;
    int           n_sent = 0;
    int           n_checked = 0;
    int           n_mismatch = 0;
    int           n_writes = 0;
    logic [31:0]  clock_us = 32'd0;  // running timestamp for press-shaped traffic

    button_debounce_press_timer_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One tick through the debounce machine, then the LED timer, then the report strobe
    function automatic t_tick_result advance_button(input logic [31:0] t_us, input logic lvl);
        logic [31:0]  now_ms;
        logic         settled;
        t_tick_result r;
        now_ms  = t_us / 32'd1000;
        settled = (now_ms - last_chg_ms) >= {16'd0, db_ms};
        case (ph)
            PHASE_CODE_UP: begin
                if (!lvl && settled) begin
                    ph          = PHASE_CODE_FALLING;
                    last_chg_ms = now_ms;
                end
            end
            PHASE_CODE_FALLING: begin
                // no debounce check here; a bounce just goes back
                if (!lvl) begin
                    ph       = PHASE_CODE_DOWN;
                    start_ms = now_ms;
                end else begin
                    ph = PHASE_CODE_UP;
                end
            end
            PHASE_CODE_DOWN: begin
                if (lvl && settled) begin
                    ph          = PHASE_CODE_RISING;
                    last_chg_ms = now_ms;
                end
            end
            default: begin
                if (lvl) begin
                    ph      = PHASE_CODE_UP;
                    held_ms = now_ms - start_ms;
                    presses = presses + 32'd1;
                end else begin
                    ph = PHASE_CODE_DOWN;
                end
            end
        endcase
        // a zero length never lights; a waiting length holds off while the LED is on
        if (ph == PHASE_CODE_UP && held_ms != 32'd0 && !led_on) begin
            led_on     = 1'b1;
            led_off_at = t_us + held_ms * 32'd1000;
            held_ms    = 32'd0;
        end
        // plain unsigned compare: a wrapped deadline turns the LED off right away
        if (led_on && t_us >= led_off_at)
            led_on = 1'b0;
        r.strobe = (t_us - last_rpt_us) >= rpt_us;
        if (r.strobe)
            last_rpt_us = t_us;
        r.led     = led_on;
        r.phase   = ph;
        r.total   = presses;
        r.pending = held_ms;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h", n_checked, what, got, want);
        n_mismatch++;
    endtask

    task automatic push_tick(input logic [31:0] t_us, input logic lvl);
        t_tick_row row;
        row.t_us  = t_us;
        row.lvl   = lvl;
        row.fixed = 1'b0;
        row.res   = NO_CHECK;
        tick_q.push_back(row);
    endtask

    // Step the running timestamp, scaled to the current debounce so presses get through
    task automatic advance_clock();
        case ($urandom_range(0, 5))
            0:       clock_us = clock_us - $urandom_range(0, 3000);
            1, 2:    clock_us = clock_us + $urandom_range(0, db_ms * 32'd1000 + 32'd999);
            default: clock_us = clock_us + (db_ms + $urandom_range(0, 40)) * 32'd1000
                                + $urandom_range(0, 999);
        endcase
    endtask

    // Mostly whole presses (lead-in, press with some chatter, release), plus noise
    task automatic gen_press_traffic(input int n);
        int made;
        int kind;
        int k;
        made = 0;
        while (made < n) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                k = $urandom_range(1, 3);
                repeat (k) begin
                    advance_clock();
                    push_tick(clock_us, 1'b1);
                    made++;
                end
                k = $urandom_range(2, 6);
                repeat (k) begin
                    advance_clock();
                    push_tick(clock_us, $urandom_range(0, 7) == 0);
                    made++;
                end
                k = $urandom_range(2, 4);
                repeat (k) begin
                    advance_clock();
                    push_tick(clock_us, $urandom_range(0, 7) != 0);
                    made++;
                end
            end else if (kind == 7) begin
                // fast chatter, a few ms apart
                k = $urandom_range(1, 6);
                repeat (k) begin
                    clock_us = clock_us + $urandom_range(0, 5999);
                    push_tick(clock_us, $urandom_range(0, 1));
                    made++;
                end
            end else if (kind == 8) begin
                // jump, often close to the 32-bit wrap
                if ($urandom_range(0, 1))
                    clock_us = 32'hFFFF_FFFF - $urandom_range(0, 200000);
                else
                    clock_us = $urandom();
                push_tick(clock_us, 1'b1);
                made++;
            end else begin
                push_tick($urandom(), $urandom_range(0, 1));
                made++;
            end
        end
    endtask

    // Register write request; the predictor takes the value once it is accepted
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DEBOUNCE_MS)
            db_ms = value[15:0];
        else
            rpt_us = value;
        n_writes++;
    endtask

    // Wait for every tick to go in and every result to come back, then let the pipe settle
    task automatic wait_drained();
        @(negedge clk);
        while (tick_q.size() != 0 || offering || tick_result_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int n_random, input logic idle, input logic squeeze);
        @(negedge clk);
        idle_on = idle;
        gen_press_traffic(n_random);
        if (squeeze)
            hold_asks++;
        wait_drained();
    endtask

    // Sender: offers ticks, predicts each one at acceptance
    always @(posedge clk) begin
        t_tick_result want;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                want = advance_button(cur.t_us, cur.lvl);
                if (cur.fixed)
                    want = cur.res;
                tick_result_q.push_back(want);
                n_sent++;
                offering = 1'b0;
                if (idle_on && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 9);
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (tick_q.size() != 0) begin
                    cur      = tick_q.pop_front();
                    offering = 1'b1;
                end
            end
            s_valid <= offering;
            s_data  <= {7'd0, cur.lvl, cur.t_us};
        end
    end

    // Receiver: random stall bursts, plus a long hold-off when asked for
    always @(posedge clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen++;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Checker: each accepted result against the oldest expectation
    always @(posedge clk) begin
        t_tick_result want;
        if (rst_n && m_valid && m_ready) begin
            if (tick_result_q.size() == 0) begin
                flag_mismatch("with nothing expected", m_data[34:3], 32'd0);
            end else begin
                want = tick_result_q.pop_front();
                if (m_data[0] !== want.led)
                    flag_mismatch("led", {31'd0, m_data[0]}, {31'd0, want.led});
                if (m_data[2:1] !== want.phase)
                    flag_mismatch("button_phase", {30'd0, m_data[2:1]}, {30'd0, want.phase});
                if (m_data[34:3] !== want.total)
                    flag_mismatch("press_total", m_data[34:3], want.total);
                if (m_data[66:35] !== want.pending)
                    flag_mismatch("pending_duration_ms", m_data[66:35], want.pending);
                if (m_data[67] !== want.strobe)
                    flag_mismatch("report_strobe", {31'd0, m_data[67]}, {31'd0, want.strobe});
            end
            n_checked++;
        end
    end

    // Watchdog: too long without any accepted request on any channel
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                     quiet, tick_result_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        db_ms       = DEBOUNCE_MS_RST;
        rpt_us      = REPORT_INTERVAL_US_RST;
        ph          = PHASE_CODE_UP;
        start_ms    = 32'd0;
        last_chg_ms = 32'd0;
        held_ms     = 32'd0;
        presses     = 32'd0;
        led_on      = 1'b0;
        led_off_at  = 32'd0;
        last_rpt_us = 32'd0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: directed walk, then press traffic
        @(negedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
            tick_q.push_back(DIRECTED_TICKS[i]);
        clock_us = 32'd6_000_000;
        run_phase(200, 1'b1, 1'b0);

        // zero debounce and zero interval: every check passes; junk in upper debounce bits
        write_reg(CFG_DEBOUNCE_MS, $urandom() & 32'hFFFF_0000);
        write_reg(CFG_REPORT_INTERVAL_US, 32'd0);
        run_phase(200, 1'b1, 1'b0);

        // largest settings
        write_reg(CFG_DEBOUNCE_MS, 32'h0000_FFFF);
        write_reg(CFG_REPORT_INTERVAL_US, 32'hFFFF_FFFF);
        run_phase(150, 1'b1, 1'b0);

        // short settings, with the receiver holding off long enough to back up the input
        write_reg(CFG_DEBOUNCE_MS, 32'd5);
        write_reg(CFG_REPORT_INTERVAL_US, 32'd1000);
        run_phase(250, 1'b1, 1'b1);

        // random middle settings
        write_reg(CFG_DEBOUNCE_MS, ($urandom() & 32'hFFFF_0000) | $urandom_range(1, 100));
        write_reg(CFG_REPORT_INTERVAL_US, $urandom_range(1, 200000));
        run_phase(250, 1'b1, 1'b0);

        // back to reset values, full rate on both sides
        write_reg(CFG_DEBOUNCE_MS, {16'd0, DEBOUNCE_MS_RST});
        write_reg(CFG_REPORT_INTERVAL_US, REPORT_INTERVAL_US_RST);
        run_phase(300, 1'b0, 1'b0);

        $display("covered %0d ticks and %0d results over %0d register writes (zero, largest,",
                 n_sent, n_checked, n_writes);
        $display("short, random and reset settings), one long output hold-off; %0d mismatches",
                 n_mismatch);
        if (n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
